FILE: src/smt_pkg.sv
// smt_pkg: shared sizes, command and status codes, and the structs that pass
// between the scan cells and the controller of the set membership table
// no dependencies
package smt_pkg;

    // capacity of the table and derived widths
    localparam int CAPACITY = 256;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // fixed field widths
    localparam int ELEM_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL = 2'd2;

    // scan token that walks down the cell chain, one cell per cycle
    typedef struct packed {
        logic [ELEM_W-1:0] key;
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
    } token_t;

    // single slot update broadcast to all cells at the end of a scan
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  idx;
        logic              set;
        logic [ELEM_W-1:0] value;
    } commit_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } ctrl_state_t;

endpackage

FILE: src/smt_cell.sv
// smt_cell: one slot of the table plus one stage of the scan chain
// depends on smt_pkg (token_t, commit_t, widths)
module smt_cell
    import smt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_idx,
    input  logic             tok_in_valid,
    input  token_t           tok_in,
    input  commit_t          commit,
    output logic             tok_out_valid,
    output token_t           tok_out
);

    logic              slot_valid_reg;
    logic [ELEM_W-1:0] slot_value_reg;
    logic              tok_valid_reg;
    token_t            tok_reg;
    token_t            tok_next;
    logic              match;
    logic              commit_here;

    // compare this slot with the passing key
    assign match       = slot_valid_reg && (slot_value_reg == tok_in.key);
    assign commit_here = commit.we && (commit.idx == cell_idx);

    // record first hit and first free slot seen along the chain
    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.hit && match)
        begin
            tok_next.hit     = 1'b1;
            tok_next.hit_idx = cell_idx;
        end
        if (!tok_in.free_found && !slot_valid_reg)
        begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = cell_idx;
        end
    end

    // control: token valid and slot valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg  <= 1'b0;
            slot_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in_valid;
            if (commit_here)
            begin
                slot_valid_reg <= commit.set;
            end
        end
    end

    // payload: token contents and stored element
    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (commit_here && commit.set)
        begin
            slot_value_reg <= commit.value;
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

FILE: src/smt_ctrl.sv
// smt_ctrl: request/response handshake, scan launch, final decision and
// element count for the set membership table
// depends on smt_pkg (codes, token_t, commit_t, ctrl_state_t)
module smt_ctrl
    import smt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [CMD_W-1:0]    command,
    input  logic signed [ELEM_W-1:0] element,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  count,
    output logic                tok_head_valid,
    output token_t              tok_head,
    input  logic                tok_tail_valid,
    input  token_t              tok_tail,
    output commit_t             commit
);

    ctrl_state_t          state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg;
    token_t               fin_reg;
    logic [CNT_W-1:0]     elems_reg, elems_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [STATUS_W-1:0]  sts_dec;
    logic                 accept;
    logic                 finish_go;
    commit_t              commit_dec;

    // one item at a time: take a new transfer only when idle
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;

    // launch the scan token into the first cell
    assign tok_head_valid = accept;
    always_comb
    begin
        tok_head            = '0;
        tok_head.key        = $unsigned(element);
    end

    // finish once the result register is free or being emptied
    assign finish_go = (state_reg == S_FINISH) && (!rsp_valid_reg || !rsp_stall);

    // decide outcome from the completed scan
    always_comb
    begin
        commit_dec       = '0;
        commit_dec.idx   = fin_reg.free_idx;
        commit_dec.value = fin_reg.key;
        sts_dec          = STS_MISS;
        elems_next       = elems_reg;
        unique case (cmd_reg)
            CMD_ADD:
            begin
                if (fin_reg.hit)
                begin
                    sts_dec = STS_MISS;
                end
                else if (!fin_reg.free_found)
                begin
                    sts_dec = STS_FULL;
                end
                else
                begin
                    commit_dec.we  = 1'b1;
                    commit_dec.set = 1'b1;
                    elems_next     = elems_reg + CNT_W'(1);
                    sts_dec        = STS_OK;
                end
            end
            CMD_REMOVE:
            begin
                if (fin_reg.hit)
                begin
                    commit_dec.we  = 1'b1;
                    commit_dec.idx = fin_reg.hit_idx;
                    commit_dec.set = 1'b0;
                    if (elems_reg != '0)
                    begin
                        elems_next = elems_reg - CNT_W'(1);
                    end
                    sts_dec = STS_OK;
                end
            end
            CMD_SEARCH:
            begin
                sts_dec = fin_reg.hit ? STS_OK : STS_MISS;
            end
            default:
            begin
                sts_dec = STS_MISS;
            end
        endcase
    end

    // broadcast the slot update only in the finishing cycle
    always_comb
    begin
        commit    = commit_dec;
        commit.we = commit_dec.we && finish_go;
    end

    // state sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tok_tail_valid)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register handshake
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (finish_go)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            elems_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (finish_go)
            begin
                elems_reg <= elems_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
        end
        if ((state_reg == S_SCAN) && tok_tail_valid)
        begin
            fin_reg <= tok_tail;
        end
        if (finish_go)
        begin
            status_reg <= sts_dec;
            count_reg  <= COUNT_W'(elems_next);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign count     = count_reg;

endmodule

FILE: src/set_membership_table_top.sv
// set_membership_table_top: the scan token crosses one cell per cycle through the chain,
// is captured in fin_reg, and the result register raises response valid once it is free
// one item at a time; a held response does not block a new scan
// reset: asynchronous active-low rst_n empties every slot and zeroes elems_reg at once
// depends on smt_pkg, smt_cell, smt_ctrl
module set_membership_table_top
    import smt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic [CMD_W-1:0]         command,
    input  logic signed [ELEM_W-1:0] element,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [COUNT_W-1:0]       count
);

    logic    tok_valid [CAPACITY+1];
    token_t  tok       [CAPACITY+1];
    commit_t commit;

    // controller: handshake, scan launch and final decision
    smt_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .command        (command),
        .element        (element),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .count          (count),
        .tok_head_valid (tok_valid[0]),
        .tok_head       (tok[0]),
        .tok_tail_valid (tok_valid[CAPACITY]),
        .tok_tail       (tok[CAPACITY]),
        .commit         (commit)
    );

    // chain of slot cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        smt_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cell_idx      (IDX_W'(i)),
            .tok_in_valid  (tok_valid[i]),
            .tok_in        (tok[i]),
            .commit        (commit),
            .tok_out_valid (tok_valid[i+1]),
            .tok_out       (tok[i+1])
        );
    end

`ifndef SYNTHESIS
    // a token leaves the chain only while a scan is in progress
    a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid[CAPACITY] |-> req_stall)
        else $error("scan token exited chain while controller idle");

    // a slot update ends the item and frees the request side
    a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        commit.we |=> !req_stall)
        else $error("controller not idle after slot update");

    // a token enters the first cell only from an accepted transfer
    a_head_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid[1] |-> $past(req_valid && !req_stall))
        else $error("scan token appeared without a request transfer");
`endif

endmodule

FILE: tb/sv/tb_set_membership_table_top.sv
`timescale 1ns / 1ps
// tb_set_membership_table_top: self-checking bench for the set membership table,
// predicts status and count per transfer and checks every response in order
// depends on smt_pkg and set_membership_table_top
module tb_set_membership_table_top;
    import smt_pkg::*;

    // command code the block does not define, still legal on the port
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_OPS     = 2000;
    localparam int SETTLE_AT      = 21;        // sender waits for an empty pipe here
    localparam int HOLDOFF_AT     = 60;        // receiver holds off after this many replies
    localparam int HOLDOFF_CYCLES = 1500;
    localparam int QUIET_LO       = 900;       // no idling on either side in this window
    localparam int QUIET_HI       = 1200;
    localparam int CYCLE_LIMIT    = 8000000;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ELEM_W-1:0] elem;
    } set_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0] sts;
        logic [COUNT_W-1:0]  cnt;
    } set_reply_t;

    typedef enum logic [2:0] {
        FILLING     = 3'b001,
        AT_CAPACITY = 3'b010,
        DRAINING    = 3'b100
    } fill_phase_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     req_valid = 1'b0;
    logic                     req_stall;
    logic [CMD_W-1:0]         command = '0;
    logic signed [ELEM_W-1:0] element = '0;
    logic                     rsp_valid;
    logic                     rsp_stall = 1'b0;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;

    set_op_t    pending_ops[$];
    set_reply_t expected_replies[$];

    // contents the stimulus expects, used to pick present and absent keys
    logic [ELEM_W-1:0] planned_set[$];

    // predicted table contents
    logic [ELEM_W-1:0] held_value[CAPACITY];
    bit                held_valid[CAPACITY];
    int                held_total = 0;

    int total_ops = 0;
    int req_sent = 0;
    int req_taken = 0;
    int replies_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int tx_gap = 0;
    int rx_burst = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;

    set_membership_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .command   (command),
        .element   (element),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .count     (count)
    );

    // clock and reset
    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // set semantics: lowest free slot on add, duplicate check ahead of full check
    function automatic set_reply_t predict_reply(logic [CMD_W-1:0] op_code,
                                                 logic [ELEM_W-1:0] key);
        set_reply_t r;
        int         hit;
        int         free_idx;
        hit = -1;
        free_idx = -1;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (held_valid[i] && held_value[i] == key && hit < 0)
                hit = i;
            if (!held_valid[i] && free_idx < 0)
                free_idx = i;
        end
        r.sts = STS_MISS;
        unique case (op_code)
            CMD_ADD:
            begin
                if (hit < 0 && free_idx < 0)
                    r.sts = STS_FULL;
                else if (hit < 0)
                begin
                    held_value[free_idx] = key;
                    held_valid[free_idx] = 1'b1;
                    held_total++;
                    r.sts = STS_OK;
                end
            end
            CMD_REMOVE:
            begin
                if (hit >= 0)
                begin
                    held_valid[hit] = 1'b0;
                    held_total--;
                    r.sts = STS_OK;
                end
            end
            CMD_SEARCH:
            begin
                if (hit >= 0)
                    r.sts = STS_OK;
            end
            default:
            begin
            end
        endcase
        r.cnt = held_total[COUNT_W-1:0];
        return r;
    endfunction

    function automatic int planned_index(logic [ELEM_W-1:0] key);
        for (int i = 0; i < planned_set.size(); i++)
        begin
            if (planned_set[i] == key)
                return i;
        end
        return -1;
    endfunction

    // a present element when asked and available, else a likely absent one
    function automatic logic [ELEM_W-1:0] pick_key(bit want_present);
        int sel;
        if (want_present && planned_set.size() > 0)
            return planned_set[$urandom_range(0, planned_set.size() - 1)];
        sel = $urandom_range(0, 3);
        if (sel == 2)
            return 32'($urandom_range(0, 63));
        if (sel == 3)
            return ~32'($urandom_range(0, 63));
        return $urandom();
    endfunction

    task automatic plan_op(logic [CMD_W-1:0] op_code, logic [ELEM_W-1:0] key);
        set_op_t op;
        int      idx;
        idx = planned_index(key);
        if (op_code == CMD_ADD && idx < 0 && planned_set.size() < CAPACITY)
            planned_set.push_back(key);
        else if (op_code == CMD_REMOVE && idx >= 0)
            planned_set.delete(idx);
        op.cmd = op_code;
        op.elem = key;
        pending_ops.push_back(op);
        total_ops++;
    endtask

    // stimulus, then wait for the pipe to drain and report
    initial
    begin : run_stimulus
        fill_phase_t phase;
        int          roll;
        int          full_left;
        phase = FILLING;
        full_left = 0;

        // empty table, extremes of the element, duplicates, re-adds, unused code
        plan_op(CMD_SEARCH, 32'h0000_0000);
        plan_op(CMD_REMOVE, 32'h7FFF_FFFF);
        plan_op(CMD_UNUSED, 32'h1234_5678);
        plan_op(CMD_ADD,    32'h8000_0000);
        plan_op(CMD_ADD,    32'h7FFF_FFFF);
        plan_op(CMD_ADD,    32'h0000_0000);
        plan_op(CMD_ADD,    32'hFFFF_FFFF);
        plan_op(CMD_ADD,    32'h8000_0000);
        plan_op(CMD_SEARCH, 32'h8000_0000);
        plan_op(CMD_SEARCH, 32'h7FFF_FFFF);
        plan_op(CMD_SEARCH, 32'h0000_0001);
        plan_op(CMD_SEARCH, 32'hFFFF_FFFE);
        plan_op(CMD_REMOVE, 32'hFFFF_FFFF);
        plan_op(CMD_REMOVE, 32'hFFFF_FFFF);
        plan_op(CMD_SEARCH, 32'hFFFF_FFFF);
        plan_op(CMD_ADD,    32'hFFFF_FFFF);
        plan_op(CMD_UNUSED, 32'hFFFF_FFFF);
        plan_op(CMD_REMOVE, 32'h8000_0000);
        plan_op(CMD_REMOVE, 32'h7FFF_FFFF);
        plan_op(CMD_REMOVE, 32'h0000_0000);
        plan_op(CMD_REMOVE, 32'hFFFF_FFFF);

        // random walk that fills the table, lingers at full, then drains it
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            roll = $urandom_range(0, 99);
            unique case (phase)
                FILLING:
                begin
                    if (roll < 70)
                        plan_op(CMD_ADD, pick_key(1'b0));
                    else if (roll < 75)
                        plan_op(CMD_ADD, pick_key(1'b1));
                    else if (roll < 85)
                        plan_op(CMD_REMOVE, pick_key(roll < 82));
                    else if (roll < 95)
                        plan_op(CMD_SEARCH, pick_key(roll[0]));
                    else
                        plan_op(CMD_UNUSED, pick_key(roll[0]));
                    if (planned_set.size() == CAPACITY)
                    begin
                        phase = AT_CAPACITY;
                        full_left = 40;
                    end
                end
                AT_CAPACITY:
                begin
                    if (roll < 45)
                        plan_op(CMD_ADD, pick_key(1'b0));
                    else if (roll < 65)
                        plan_op(CMD_ADD, pick_key(1'b1));
                    else if (roll < 85)
                        plan_op(CMD_SEARCH, pick_key(roll[0]));
                    else if (roll < 92)
                        plan_op(CMD_REMOVE, pick_key(1'b0));
                    else
                        plan_op(CMD_UNUSED, pick_key(roll[0]));
                    full_left--;
                    if (full_left == 0)
                        phase = DRAINING;
                end
                default:
                begin
                    if (roll < 70)
                        plan_op(CMD_REMOVE, pick_key(1'b1));
                    else if (roll < 75)
                        plan_op(CMD_REMOVE, pick_key(1'b0));
                    else if (roll < 85)
                        plan_op(CMD_ADD, pick_key(1'b0));
                    else if (roll < 95)
                        plan_op(CMD_SEARCH, pick_key(roll[0]));
                    else
                        plan_op(CMD_UNUSED, pick_key(roll[0]));
                    if (planned_set.size() == 0)
                        phase = FILLING;
                end
            endcase
        end

        while (req_taken < total_ops || expected_replies.size() != 0)
            @(posedge clk);
        // catch any stray response after the last expected one
        repeat (2 * (CAPACITY + 2)) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // request driver: holds a stalled transfer, otherwise idles or offers the next op
    always @(negedge clk)
    begin : drive_requests
        set_op_t op;
        bit      quiet_tx;
        quiet_tx = (req_sent >= QUIET_LO && req_sent < QUIET_HI);
        if (rst_n && !(req_valid && req_taken != req_sent))
        begin
            // occasional long gap after a transfer, so arrivals land on every scan phase
            if (req_valid && !quiet_tx && $urandom_range(0, 7) == 0)
                tx_gap = $urandom_range(1, 600);
            if (tx_gap > 0)
            begin
                tx_gap--;
                req_valid <= 1'b0;
            end
            else if (pending_ops.size() == 0
                     || (req_sent == SETTLE_AT && expected_replies.size() != 0)
                     || (!quiet_tx && $urandom_range(0, 99) < 37))
            begin
                req_valid <= 1'b0;
            end
            else
            begin
                op = pending_ops.pop_front();
                command <= op.cmd;
                element <= op.elem;
                req_valid <= 1'b1;
                req_sent++;
            end
        end
    end

    // response stall: one long hold-off, rare bursts and single cycles
    always @(negedge clk)
    begin : drive_stall
        if (rst_n)
        begin
            if (!holdoff_done && replies_seen >= HOLDOFF_AT)
            begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                rsp_stall <= 1'b1;
            end
            else if (rx_burst > 0)
            begin
                rx_burst--;
                rsp_stall <= 1'b1;
            end
            else if (replies_seen >= QUIET_LO && replies_seen < QUIET_HI)
            begin
                rsp_stall <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 1999) == 0)
                    rx_burst = $urandom_range(1, 300);
                rsp_stall <= ($urandom_range(0, 99) < 37);
            end
        end
    end

    // monitor: predict on each request transfer, check each response transfer
    always @(posedge clk)
    begin : watch_ports
        set_reply_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                expected_replies.push_back(predict_reply(command, element));
                req_taken <= req_taken + 1;
            end
            if (rsp_valid && !rsp_stall)
            begin
                replies_seen <= replies_seen + 1;
                if (expected_replies.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("reply %0d with nothing outstanding: status %0d count %0d",
                                 replies_seen, status, count);
                    mismatches++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (status !== want.sts || count !== want.cnt)
                    begin
                        if (mismatches < 10)
                            $display("reply %0d: expected status %0d count %0d, got %0d %0d",
                                     replies_seen, want.sts, want.cnt, status, count);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
